// ===== rtl/ftpf_pkg.sv =====
package ftpf_pkg;

  localparam int RULE_COUNT = 16;
  localparam int SLOT_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [16:0] ANY_PORT  = 17'h1ffff;
  localparam logic [8:0]  ANY_PROTO = 9'h1ff;
  localparam logic [31:0] ANY_IP    = 32'd0;

  localparam logic [6:0] LEN_ETH = 7'd14;
  localparam logic [6:0] LEN_IP  = 7'd34;
  localparam logic [6:0] LEN_UDP = 7'd42;
  localparam logic [6:0] LEN_TCP = 7'd54;

  localparam logic [5:0] OFFSET_MAX   = 6'd63;
  localparam logic [5:0] POS_ETYPE_HI = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO = 6'd13;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_SIP      = 6'd26;
  localparam logic [5:0] POS_SIP_END  = 6'd29;
  localparam logic [5:0] POS_DIP      = 6'd30;
  localparam logic [5:0] POS_DIP_END  = 6'd33;
  localparam logic [5:0] POS_PORT     = 6'd34;
  localparam logic [5:0] POS_PORT_END = 6'd37;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_RULE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_TRUNC = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

  typedef struct packed {
    logic        white;
    logic [8:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [16:0] sport;
    logic [16:0] dport;
  } rule_t;

  typedef struct packed {
    logic skip;
    logic hit;
  } match_t;

endpackage

// ===== rtl/ftpf_in_if.sv =====
interface ftpf_in_if;
  logic                 valid;
  logic                 ready;
  ftpf_pkg::opcode_t    opcode;
  logic [7:0]           frame_byte;
  logic                 frame_end;
  logic [3:0]           rule_slot;
  logic                 rule_enable;
  logic                 rule_is_white;
  logic [31:0]          rule_source_ip;
  logic [31:0]          rule_dest_ip;
  logic signed [16:0]   rule_source_port;
  logic signed [16:0]   rule_dest_port;
  logic signed [8:0]    rule_protocol;

  modport source (
    output valid, opcode, frame_byte, frame_end, rule_slot, rule_enable, rule_is_white,
    output rule_source_ip, rule_dest_ip, rule_source_port, rule_dest_port, rule_protocol,
    input  ready
  );

  modport sink (
    input  valid, opcode, frame_byte, frame_end, rule_slot, rule_enable, rule_is_white,
    input  rule_source_ip, rule_dest_ip, rule_source_port, rule_dest_port, rule_protocol,
    output ready
  );
endinterface

// ===== rtl/ftpf_out_if.sv =====
interface ftpf_out_if;
  logic               valid;
  logic               ready;
  ftpf_pkg::verdict_t verdict;

  modport source (
    output valid, verdict,
    input  ready
  );

  modport sink (
    input  valid, verdict,
    output ready
  );
endinterface

// ===== rtl/ftpf_ram.sv =====
module ftpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ftpf_parse.sv =====
module ftpf_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic [7:0]          frame_byte,
  input  logic                frame_end,
  input  logic                clear,
  output logic [5:0]          offset,
  output ftpf_pkg::hdr_t      hdr
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      offset <= '0;
      hdr    <= '0;
    end else if (byte_valid) begin
      if (!frame_end && offset != ftpf_pkg::OFFSET_MAX) begin
        offset <= offset + 6'd1;
      end
      priority if (offset == ftpf_pkg::POS_ETYPE_HI || offset == ftpf_pkg::POS_ETYPE_LO) begin
        hdr.ether_type <= {hdr.ether_type[7:0], frame_byte};
      end else if (offset == ftpf_pkg::POS_PROTO) begin
        hdr.ip_protocol <= frame_byte;
      end else if (offset >= ftpf_pkg::POS_SIP && offset <= ftpf_pkg::POS_SIP_END) begin
        hdr.src_ip <= {hdr.src_ip[23:0], frame_byte};
      end else if (offset >= ftpf_pkg::POS_DIP && offset <= ftpf_pkg::POS_DIP_END) begin
        hdr.dst_ip <= {hdr.dst_ip[23:0], frame_byte};
      end else if (offset >= ftpf_pkg::POS_PORT && offset <= ftpf_pkg::POS_PORT_END) begin
        hdr.sport <= {hdr.sport[7:0], hdr.dport[15:8]};
        hdr.dport <= {hdr.dport[7:0], frame_byte};
      end else begin
        hdr <= hdr;
      end
    end
  end

endmodule

// ===== rtl/ftpf_match.sv =====
module ftpf_match (
  input  ftpf_pkg::rule_t   rule,
  input  ftpf_pkg::hdr_t    hdr,
  output ftpf_pkg::match_t  result
);

  logic has_ports;
  logic any_sport;
  logic any_dport;

  assign has_ports = (hdr.ip_protocol == ftpf_pkg::PROTO_TCP) ||
                     (hdr.ip_protocol == ftpf_pkg::PROTO_UDP);
  assign any_sport = (rule.sport == ftpf_pkg::ANY_PORT);
  assign any_dport = (rule.dport == ftpf_pkg::ANY_PORT);

  always_comb begin
    result.skip = !has_ports && !(any_sport && any_dport);
    result.hit  = (rule.protocol == ftpf_pkg::ANY_PROTO ||
                   rule.protocol == {1'b0, hdr.ip_protocol}) &&
                  (rule.src_ip == ftpf_pkg::ANY_IP || rule.src_ip == hdr.src_ip) &&
                  (rule.dst_ip == ftpf_pkg::ANY_IP || rule.dst_ip == hdr.dst_ip) &&
                  (any_sport || rule.sport == {1'b0, hdr.sport}) &&
                  (any_dport || rule.dport == {1'b0, hdr.dport});
  end

endmodule

// ===== rtl/five_tuple_packet_filter.sv =====
// five-tuple packet filter
// din carries words of two kinds: opcode OP_RULE writes one rule slot, OP_FRAME
// delivers one ethernet frame byte in wire order, frame_end marking the last one.
// dout carries one verdict word per frame: pass, drop or truncated.
// rule writes and frame bytes other than the last are taken back to back while
// the block is idle. after the last byte din.ready stays low while the sequencer
// works: a header check state, then the shared compare unit goes over every rule
// slot one at a time (rule ram read, then compare), where a disabled slot never
// drops, stopping at the first dropping rule. short, non-ip or truncated frames
// go from the header check straight to the done state, and in every case the
// verdict is then registered into dout.
// dout is a register: while the receiver stalls, the block keeps taking words
// until the next frame ends, then waits with din.ready low until the held
// verdict is taken.
// reset disables all rules, clears the byte counter and captured header, and
// empties dout; rule contents other than the enable are not cleared.
module five_tuple_packet_filter (
  input  logic        clk,
  input  logic        rst,
  ftpf_in_if.sink     din,
  ftpf_out_if.source  dout
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HDR   = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [ftpf_pkg::SLOT_W-1:0]  idx;
  logic [6:0]                   frame_len;
  ftpf_pkg::verdict_t           verdict;
  logic [ftpf_pkg::RULE_COUNT-1:0] rule_en;
  logic                         out_valid;
  ftpf_pkg::verdict_t           out_verdict;

  logic                         acc;
  logic                         frame_acc;
  logic                         slot_ok;
  logic                         wr_rule;
  logic [ftpf_pkg::SLOT_W-1:0]  wr_slot;
  logic                         out_free;
  logic                         drop;
  logic                         last_slot;
  logic [5:0]                   offset;
  ftpf_pkg::hdr_t               hdr;
  ftpf_pkg::rule_t              rule_wdata;
  ftpf_pkg::rule_t              rule_rdata;
  ftpf_pkg::match_t             match;

  assign din.ready   = (state == ST_IDLE);
  assign dout.valid  = out_valid;
  assign dout.verdict = out_verdict;

  assign acc       = din.valid && din.ready;
  assign frame_acc = acc && din.opcode == ftpf_pkg::OP_FRAME;
  assign slot_ok   = (32'(din.rule_slot) < ftpf_pkg::RULE_COUNT);
  assign wr_rule   = acc && din.opcode == ftpf_pkg::OP_RULE && slot_ok;
  assign wr_slot   = ftpf_pkg::SLOT_W'(din.rule_slot);
  assign out_free  = !out_valid || dout.ready;
  assign last_slot = (idx == ftpf_pkg::SLOT_W'(ftpf_pkg::RULE_COUNT - 1));
  assign drop      = rule_en[idx] && !match.skip && (match.hit != rule_rdata.white);

  always_comb begin
    rule_wdata.white    = din.rule_is_white;
    rule_wdata.protocol = din.rule_protocol;
    rule_wdata.src_ip   = din.rule_source_ip;
    rule_wdata.dst_ip   = din.rule_dest_ip;
    rule_wdata.sport    = din.rule_source_port;
    rule_wdata.dport    = din.rule_dest_port;
  end

  ftpf_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (frame_acc),
    .frame_byte (din.frame_byte),
    .frame_end  (din.frame_end),
    .clear      (state == ST_DONE && out_free),
    .offset     (offset),
    .hdr        (hdr)
  );

  ftpf_ram #(
    .WIDTH ($bits(ftpf_pkg::rule_t)),
    .DEPTH (ftpf_pkg::RULE_COUNT)
  ) u_rules (
    .clk   (clk),
    .we    (wr_rule),
    .waddr (wr_slot),
    .wdata (rule_wdata),
    .raddr (idx),
    .rdata (rule_rdata)
  );

  ftpf_match u_match (
    .rule   (rule_rdata),
    .hdr    (hdr),
    .result (match)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (frame_acc && din.frame_end) begin
          state_next = ST_HDR;
        end
      end
      ST_HDR: begin
        priority if (frame_len <= ftpf_pkg::LEN_ETH ||
                     hdr.ether_type != ftpf_pkg::ETYPE_IPV4 ||
                     frame_len <= ftpf_pkg::LEN_IP ||
                     (hdr.ip_protocol == ftpf_pkg::PROTO_TCP && frame_len <= ftpf_pkg::LEN_TCP) ||
                     (hdr.ip_protocol == ftpf_pkg::PROTO_UDP && frame_len <= ftpf_pkg::LEN_UDP)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_FETCH: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (drop || last_slot) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rule_en   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_rule) begin
        rule_en[wr_slot] <= din.rule_enable;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc && din.frame_end) begin
      frame_len <= {1'b0, offset} + 7'd1;
      idx       <= '0;
    end
    if (state == ST_HDR) begin
      priority if (frame_len <= ftpf_pkg::LEN_ETH) begin
        verdict <= ftpf_pkg::VERDICT_TRUNC;
      end else if (hdr.ether_type != ftpf_pkg::ETYPE_IPV4) begin
        verdict <= ftpf_pkg::VERDICT_PASS;
      end else if (frame_len <= ftpf_pkg::LEN_IP ||
                   (hdr.ip_protocol == ftpf_pkg::PROTO_TCP && frame_len <= ftpf_pkg::LEN_TCP) ||
                   (hdr.ip_protocol == ftpf_pkg::PROTO_UDP && frame_len <= ftpf_pkg::LEN_UDP)) begin
        verdict <= ftpf_pkg::VERDICT_TRUNC;
      end else begin
        verdict <= ftpf_pkg::VERDICT_PASS;
      end
    end
    if (state == ST_CHECK) begin
      if (drop) begin
        verdict <= ftpf_pkg::VERDICT_DROP;
      end else if (!last_slot) begin
        idx <= idx + 1'b1;
      end
    end
    if (state == ST_DONE && out_free) begin
      out_verdict <= verdict;
    end
  end

  a_end_to_hdr: assert property (@(posedge clk) disable iff (rst)
    (frame_acc && din.frame_end) |=> state == ST_HDR)
    else $error("last frame word did not start the decision");

  a_drop_stops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && drop) |=> (state == ST_DONE && verdict == ftpf_pkg::VERDICT_DROP))
    else $error("dropping rule did not end the scan");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("verdict not loaded into output register");

  a_rule_enable: assert property (@(posedge clk) disable iff (rst)
    wr_rule |=> rule_en[$past(wr_slot)] == $past(din.rule_enable))
    else $error("rule enable not written");

endmodule

// ===== sim/tb_five_tuple_packet_filter.sv =====
`timescale 1ns / 100ps

module tb_five_tuple_packet_filter;

  localparam int ITEM_TARGET = 1750;
  localparam int FRAME_TARGET = 40;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 2 * ftpf_pkg::RULE_COUNT + 8;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [31:0] HOST_A = 32'h0a000001;
  localparam logic [31:0] HOST_B = 32'hc0a80a14;
  localparam logic [31:0] HOST_ONES = 32'hffffffff;

  typedef struct {
    ftpf_pkg::opcode_t op;
    logic [7:0]  fbyte;
    logic        last;
    logic [3:0]  slot;
    logic        en;
    logic        white;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [16:0] sport;
    logic [16:0] dport;
    logic [8:0]  proto;
  } word_t;

  typedef struct {
    bit          is_rule;
    bit          mid;
    bit          typed;
    ftpf_pkg::verdict_t tv;
    word_t       rule;
    int          len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftpf_in_if  din_if ();
  ftpf_out_if dout_if ();

  five_tuple_packet_filter uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame tracker and rule table
  logic [5:0]  trk_pos;
  logic [15:0] trk_etype;
  logic [7:0]  trk_proto;
  logic [31:0] trk_sip;
  logic [31:0] trk_dip;
  logic [31:0] trk_ports;
  ftpf_pkg::rule_t rule_mem [ftpf_pkg::RULE_COUNT];
  logic            rule_on  [ftpf_pkg::RULE_COUNT];

  ftpf_pkg::verdict_t pending_verdicts [$];
  row_t plan [$];

  int  tx_max = 2;
  int  rx_max = 2;
  bit  hold_request = 1'b0;
  int  idle_cycles = 0;
  int  error_count = 0;
  int  words_sent = 0;
  int  frames_sent = 0;
  int  rules_sent = 0;
  int  mid_writes = 0;
  int  pass_seen = 0;
  int  drop_seen = 0;
  int  trunc_seen = 0;

  function automatic void add_row(input row_t r);
    plan = {plan, r};
  endfunction

  function automatic ftpf_pkg::verdict_t judge_frame(input int len);
    logic has_ports;
    logic ok;
    ftpf_pkg::rule_t rl;
    if (len <= int'(ftpf_pkg::LEN_ETH)) return ftpf_pkg::VERDICT_TRUNC;
    if (trk_etype != ftpf_pkg::ETYPE_IPV4) return ftpf_pkg::VERDICT_PASS;
    if (len <= int'(ftpf_pkg::LEN_IP)) return ftpf_pkg::VERDICT_TRUNC;
    if (trk_proto == ftpf_pkg::PROTO_TCP && len <= int'(ftpf_pkg::LEN_TCP))
      return ftpf_pkg::VERDICT_TRUNC;
    if (trk_proto == ftpf_pkg::PROTO_UDP && len <= int'(ftpf_pkg::LEN_UDP))
      return ftpf_pkg::VERDICT_TRUNC;
    has_ports = (trk_proto == ftpf_pkg::PROTO_TCP) || (trk_proto == ftpf_pkg::PROTO_UDP);
    for (int i = 0; i < ftpf_pkg::RULE_COUNT; i++) begin
      if (!rule_on[i]) continue;
      rl = rule_mem[i];
      if (!has_ports && (rl.sport != ftpf_pkg::ANY_PORT || rl.dport != ftpf_pkg::ANY_PORT))
        continue;
      ok = 1'b1;
      if (rl.protocol != ftpf_pkg::ANY_PROTO && rl.protocol != {1'b0, trk_proto}) ok = 1'b0;
      if (rl.src_ip != ftpf_pkg::ANY_IP && rl.src_ip != trk_sip) ok = 1'b0;
      if (rl.dst_ip != ftpf_pkg::ANY_IP && rl.dst_ip != trk_dip) ok = 1'b0;
      if (rl.sport != ftpf_pkg::ANY_PORT && rl.sport != {1'b0, trk_ports[31:16]}) ok = 1'b0;
      if (rl.dport != ftpf_pkg::ANY_PORT && rl.dport != {1'b0, trk_ports[15:0]}) ok = 1'b0;
      if (ok != rl.white) return ftpf_pkg::VERDICT_DROP;
    end
    return ftpf_pkg::VERDICT_PASS;
  endfunction

  task automatic track_word(input word_t w, output logic done, output ftpf_pkg::verdict_t v);
    int pos;
    done = 1'b0;
    v = ftpf_pkg::VERDICT_PASS;
    if (w.op == ftpf_pkg::OP_RULE) begin
      if (int'(w.slot) < ftpf_pkg::RULE_COUNT) begin
        rule_on[w.slot] = w.en;
        rule_mem[w.slot] = '{white: w.white, protocol: w.proto, src_ip: w.sip,
                             dst_ip: w.dip, sport: w.sport, dport: w.dport};
      end
    end else begin
      pos = int'(trk_pos);
      if (pos == 12 || pos == 13) trk_etype = {trk_etype[7:0], w.fbyte};
      else if (pos == 23) trk_proto = w.fbyte;
      else if (pos >= 26 && pos <= 29) trk_sip = {trk_sip[23:0], w.fbyte};
      else if (pos >= 30 && pos <= 33) trk_dip = {trk_dip[23:0], w.fbyte};
      else if (pos >= 34 && pos <= 37) trk_ports = {trk_ports[23:0], w.fbyte};
      if (w.last) begin
        v = judge_frame(pos + 1);
        done = 1'b1;
        trk_pos = '0;
        trk_etype = '0;
        trk_proto = '0;
        trk_sip = '0;
        trk_dip = '0;
        trk_ports = '0;
      end else if (trk_pos < ftpf_pkg::OFFSET_MAX) begin
        trk_pos = trk_pos + 6'd1;
      end
    end
  endtask

  function automatic word_t rand_word();
    word_t w;
    w.op = ftpf_pkg::OP_FRAME;
    w.fbyte = 8'($urandom);
    w.last = 1'($urandom);
    w.slot = 4'($urandom);
    w.en = 1'($urandom);
    w.white = 1'($urandom);
    w.sip = $urandom;
    w.dip = $urandom;
    w.sport = 17'($urandom);
    w.dport = 17'($urandom);
    w.proto = 9'($urandom);
    return w;
  endfunction

  function automatic word_t rule_word(input logic [3:0] slot, input logic en, input logic white,
                                      input logic [31:0] sip, input logic [31:0] dip,
                                      input logic [16:0] sport, input logic [16:0] dport,
                                      input logic [8:0] proto);
    word_t w;
    w = rand_word();
    w.op = ftpf_pkg::OP_RULE;
    w.slot = slot;
    w.en = en;
    w.white = white;
    w.sip = sip;
    w.dip = dip;
    w.sport = sport;
    w.dport = dport;
    w.proto = proto;
    return w;
  endfunction

  function automatic row_t rule_row(input word_t w);
    row_t r;
    r.is_rule = 1'b1;
    r.mid = 1'b0;
    r.typed = 1'b0;
    r.tv = ftpf_pkg::VERDICT_PASS;
    r.rule = w;
    r.len = 0;
    return r;
  endfunction

  function automatic row_t frame_row(input int len, input logic [15:0] etype,
                                     input logic [7:0] proto, input logic [31:0] sip,
                                     input logic [31:0] dip, input logic [15:0] sport,
                                     input logic [15:0] dport, input bit typed,
                                     input ftpf_pkg::verdict_t tv);
    row_t r;
    r.is_rule = 1'b0;
    r.mid = 1'b0;
    r.typed = typed;
    r.tv = tv;
    r.rule = rand_word();
    r.len = len;
    r.etype = etype;
    r.proto = proto;
    r.sip = sip;
    r.dip = dip;
    r.sport = sport;
    r.dport = dport;
    return r;
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 4))
      0: return HOST_A;
      1: return HOST_B;
      2: return HOST_ONES;
      3: return 32'h00000001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd80;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t rand_rule(input logic [3:0] slot, input logic en, input bit white_ok);
    logic [31:0] sip;
    logic [31:0] dip;
    logic [16:0] sport;
    logic [16:0] dport;
    logic [8:0]  proto;
    logic        white;
    sip = ($urandom_range(0, 1) == 0) ? ftpf_pkg::ANY_IP : pick_ip();
    dip = ($urandom_range(0, 1) == 0) ? ftpf_pkg::ANY_IP : pick_ip();
    case ($urandom_range(0, 5))
      0, 1, 2: sport = ftpf_pkg::ANY_PORT;
      3, 4: sport = {1'b0, pick_port()};
      default: sport = 17'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: dport = ftpf_pkg::ANY_PORT;
      3, 4: dport = {1'b0, pick_port()};
      default: dport = 17'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1: proto = ftpf_pkg::ANY_PROTO;
      2: proto = {1'b0, ftpf_pkg::PROTO_TCP};
      3: proto = {1'b0, ftpf_pkg::PROTO_UDP};
      default: proto = 9'($urandom);
    endcase
    white = white_ok && ($urandom_range(0, 1) == 1);
    return rule_word(slot, en, white, sip, dip, sport, dport, proto);
  endfunction

  function automatic row_t rand_frame();
    row_t r;
    r = frame_row(60, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, pick_ip(), pick_ip(),
                  pick_port(), pick_port(), 1'b0, ftpf_pkg::VERDICT_PASS);
    case ($urandom_range(0, 11))
      0: begin
        r.len = $urandom_range(1, 15);
        if ($urandom_range(0, 1) == 0) r.etype = 16'($urandom);
      end
      1: begin
        r.len = $urandom_range(15, 64);
        r.etype = ($urandom_range(0, 1) == 0) ? ETYPE_ARP : 16'($urandom);
      end
      2: begin
        r.len = $urandom_range(15, 56);
        r.proto = ($urandom_range(0, 1) == 0) ? ftpf_pkg::PROTO_UDP : 8'($urandom);
      end
      3, 4, 5, 6: begin
        r.len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 90) : $urandom_range(55, 60);
      end
      7, 8, 9: begin
        r.proto = ftpf_pkg::PROTO_UDP;
        r.len = $urandom_range(43, 50);
      end
      default: begin
        r.proto = 8'($urandom);
        r.len = $urandom_range(35, 50);
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input ftpf_pkg::verdict_t tv);
    int       gap;
    logic     done;
    ftpf_pkg::verdict_t v;
    gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.opcode <= w.op;
    din_if.frame_byte <= w.fbyte;
    din_if.frame_end <= w.last;
    din_if.rule_slot <= w.slot;
    din_if.rule_enable <= w.en;
    din_if.rule_is_white <= w.white;
    din_if.rule_source_ip <= w.sip;
    din_if.rule_dest_ip <= w.dip;
    din_if.rule_source_port <= w.sport;
    din_if.rule_dest_port <= w.dport;
    din_if.rule_protocol <= w.proto;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    track_word(w, done, v);
    if (done) begin
      pending_verdicts = {pending_verdicts, (typed ? tv : v)};
      frames_sent++;
    end
    if (w.op == ftpf_pkg::OP_RULE) rules_sent++;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input row_t r, input int mid_at);
    word_t w;
    for (int i = 0; i < r.len; i++) begin
      if (i == mid_at) begin
        send_word(r.rule, 1'b0, ftpf_pkg::VERDICT_PASS);
        mid_writes++;
      end
      w = rand_word();
      w.op = ftpf_pkg::OP_FRAME;
      w.last = (i == r.len - 1);
      case (i)
        12: w.fbyte = r.etype[15:8];
        13: w.fbyte = r.etype[7:0];
        23: w.fbyte = r.proto;
        26, 27, 28, 29: w.fbyte = r.sip[8 * (29 - i) +: 8];
        30, 31, 32, 33: w.fbyte = r.dip[8 * (33 - i) +: 8];
        34: w.fbyte = r.sport[15:8];
        35: w.fbyte = r.sport[7:0];
        36: w.fbyte = r.dport[15:8];
        37: w.fbyte = r.dport[7:0];
        default: ;
      endcase
      send_word(w, r.typed, r.tv);
    end
  endtask

  always @(posedge clk) begin
    ftpf_pkg::verdict_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (dout_if.valid && dout_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict: no word expected, actual %0d", dout_if.verdict);
          error_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (dout_if.verdict !== want) begin
            $error("verdict mismatch: expected %0d, actual %0d", want, dout_if.verdict);
            error_count++;
          end
          case (want)
            ftpf_pkg::VERDICT_PASS: pass_seen++;
            ftpf_pkg::VERDICT_DROP: drop_seen++;
            default: trunc_seen++;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int stall;
    dout_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
      end
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dout_if.ready <= 1'b1;
      @(posedge clk);
      while (!dout_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : sender
    row_t r;
    int   phase;
    bit   white_ok;
    bit   mid;

    din_if.valid = 1'b0;
    din_if.opcode = ftpf_pkg::OP_FRAME;
    din_if.frame_byte = '0;
    din_if.frame_end = 1'b0;
    din_if.rule_slot = '0;
    din_if.rule_enable = 1'b0;
    din_if.rule_is_white = 1'b0;
    din_if.rule_source_ip = '0;
    din_if.rule_dest_ip = '0;
    din_if.rule_source_port = '0;
    din_if.rule_dest_port = '0;
    din_if.rule_protocol = '0;

    trk_pos = '0;
    trk_etype = '0;
    trk_proto = '0;
    trk_sip = '0;
    trk_dip = '0;
    trk_ports = '0;
    for (int i = 0; i < ftpf_pkg::RULE_COUNT; i++) rule_on[i] = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // truncation limits and non-ip frames with an empty table
    add_row(frame_row(1, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_TRUNC));
    add_row(frame_row(14, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_TRUNC));
    add_row(frame_row(15, ETYPE_ARP, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(60, 16'hffff, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(34, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_TRUNC));
    add_row(frame_row(54, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_TRUNC));
    add_row(frame_row(42, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_UDP, HOST_A, HOST_B, 16'd53,
                      16'd53, 1'b1, ftpf_pkg::VERDICT_TRUNC));
    add_row(frame_row(43, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_UDP, HOST_A, HOST_B, 16'd53,
                      16'd53, 1'b1, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(55, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'd443, 1'b1, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(35, ftpf_pkg::ETYPE_IPV4, 8'hff, HOST_A, HOST_B, 16'd0, 16'd0,
                      1'b1, ftpf_pkg::VERDICT_PASS));
    // catch-all black rule, then overwritten disabled with extreme values
    add_row(rule_row(rule_word(4'd0, 1'b1, 1'b0, ftpf_pkg::ANY_IP, ftpf_pkg::ANY_IP,
                               ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PROTO)));
    add_row(frame_row(60, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd0,
                      16'hffff, 1'b1, ftpf_pkg::VERDICT_DROP));
    add_row(rule_row(rule_word(4'd0, 1'b0, 1'b1, HOST_ONES, HOST_ONES, 17'h1fffe,
                               17'h00000, 9'h100)));
    add_row(frame_row(40, ftpf_pkg::ETYPE_IPV4, 8'h00, 32'h0, HOST_ONES, 16'd0, 16'd0,
                      1'b1, ftpf_pkg::VERDICT_PASS));
    // white rule on source and protocol
    add_row(rule_row(rule_word(4'd15, 1'b1, 1'b1, HOST_ONES, ftpf_pkg::ANY_IP,
                               ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PORT,
                               {1'b0, ftpf_pkg::PROTO_TCP})));
    add_row(frame_row(64, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_ONES, HOST_B,
                      16'hffff, 16'd0, 1'b0, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(80, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_UDP, HOST_ONES, HOST_B,
                      16'd1, 16'd2, 1'b0, ftpf_pkg::VERDICT_PASS));
    // port rule: skipped on a portless frame, hits on tcp
    add_row(rule_row(rule_word(4'd15, 1'b1, 1'b0, ftpf_pkg::ANY_IP, ftpf_pkg::ANY_IP, 17'd80,
                               17'h0ffff, ftpf_pkg::ANY_PROTO)));
    add_row(frame_row(40, ftpf_pkg::ETYPE_IPV4, 8'd1, HOST_A, HOST_B, 16'd80, 16'hffff,
                      1'b0, ftpf_pkg::VERDICT_PASS));
    add_row(frame_row(60, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                      16'hffff, 1'b0, ftpf_pkg::VERDICT_PASS));
    // negative port other than any, and a rule disabled in the middle of a frame
    add_row(rule_row(rule_word(4'd7, 1'b1, 1'b0, ftpf_pkg::ANY_IP, ftpf_pkg::ANY_IP,
                               17'h10000, ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PROTO)));
    r = frame_row(60, ftpf_pkg::ETYPE_IPV4, ftpf_pkg::PROTO_TCP, HOST_A, HOST_B, 16'd80,
                  16'hffff, 1'b0, ftpf_pkg::VERDICT_PASS);
    r.mid = 1'b1;
    r.rule = rule_word(4'd15, 1'b0, 1'b0, ftpf_pkg::ANY_IP, ftpf_pkg::ANY_IP,
                       ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PROTO);
    add_row(r);
    add_row(rule_row(rule_word(4'd7, 1'b1, 1'b0, ftpf_pkg::ANY_IP, HOST_B, ftpf_pkg::ANY_PORT,
                               ftpf_pkg::ANY_PORT, 9'h0ff)));
    add_row(frame_row(50, ftpf_pkg::ETYPE_IPV4, 8'hff, HOST_A, HOST_B, 16'd0, 16'd0,
                      1'b0, ftpf_pkg::VERDICT_PASS));
    add_row(rule_row(rule_word(4'd7, 1'b0, 1'b0, ftpf_pkg::ANY_IP, ftpf_pkg::ANY_IP,
                               ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PORT, ftpf_pkg::ANY_PROTO)));

    foreach (plan[i]) begin
      if (plan[i].is_rule) send_word(plan[i].rule, 1'b0, ftpf_pkg::VERDICT_PASS);
      else send_frame(plan[i], plan[i].mid ? 20 : -1);
    end

    phase = 0;
    while (words_sent < ITEM_TARGET || frames_sent < FRAME_TARGET) begin
      case ($urandom_range(0, 2))
        0: tx_max = 0;
        1: tx_max = 3;
        default: tx_max = 6;
      endcase
      case ($urandom_range(0, 2))
        0: rx_max = 0;
        1: rx_max = 3;
        default: rx_max = 6;
      endcase
      if (phase == 1) begin
        hold_request = 1'b1;
        tx_max = 0;
      end
      if (phase == 0 || $urandom_range(0, 1) == 0) begin
        white_ok = ($urandom_range(0, 2) == 0);
        for (int s = 0; s < ftpf_pkg::RULE_COUNT; s++)
          send_word(rand_rule(4'(s), $urandom_range(0, 3) == 0, white_ok), 1'b0,
                    ftpf_pkg::VERDICT_PASS);
      end
      repeat (6) begin
        if (words_sent >= ITEM_TARGET && frames_sent >= FRAME_TARGET) break;
        r = rand_frame();
        mid = (r.len > 1) && ($urandom_range(0, 9) == 0);
        if (mid)
          r.rule = rand_rule(4'($urandom), $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        send_frame(r, mid ? int'($urandom_range(1, r.len - 1)) : -1);
      end
      phase++;
    end
    din_if.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words in: %0d frames, %0d rule writes, %0d written inside a frame",
             words_sent, frames_sent, rules_sent, mid_writes);
    $display("verdicts checked: %0d pass, %0d drop, %0d truncated; one long output stall",
             pass_seen, drop_seen, trunc_seen);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== five_tuple_packet_filter.f =====
rtl/ftpf_pkg.sv
rtl/ftpf_in_if.sv
rtl/ftpf_out_if.sv
rtl/ftpf_ram.sv
rtl/ftpf_parse.sv
rtl/ftpf_match.sv
rtl/five_tuple_packet_filter.sv
sim/tb_five_tuple_packet_filter.sv
